FILE: rtl/core/rbst_pkg.sv
// shared types, constants and helpers for the 2d ray/box slab test
// no dependencies
`default_nettype none
package rbst_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int T_W           = 32;
    localparam int EPS_W         = 31;
    localparam logic [EPS_W-1:0] EPS_RESET = 31'd66;
    localparam int QBITS         = 32;
    localparam int DIV_STEP      = 4;
    localparam int DIV_STAGES    = QBITS / DIV_STEP;
    localparam int DIV_LAT       = DIV_STAGES + 1;
    localparam int DW            = 65;

    localparam logic [1:0] HIT_NONE   = 2'd0;
    localparam logic [1:0] HIT_INSIDE = 2'd1;
    localparam logic [1:0] HIT_ENTER  = 2'd2;

    localparam logic signed [T_W-1:0] T_LOWEST  = 32'sh8000_0000;
    localparam logic signed [T_W-1:0] T_HIGHEST = 32'sh7fff_ffff;

    typedef struct packed {
        logic par_x;
        logic par_y;
        logic rej;
        logic dneg_x;
        logic dneg_y;
        logic qneg_lx;
        logic qneg_hx;
        logic qneg_ly;
        logic qneg_hy;
    } t_side;

    function automatic logic signed [T_W-1:0] sat_quo(input logic [QBITS-1:0] quo,
                                                     input logic ovf,
                                                     input logic neg);
        logic signed [T_W-1:0] res;
        if (neg) begin
            if (ovf || (quo > 32'h8000_0000)) res = T_LOWEST;
            else res = T_W'(-$signed(quo));
        end else begin
            if (ovf || quo[QBITS-1]) res = T_HIGHEST;
            else res = $signed(quo);
        end
        return res;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/rbst_div.sv
// pipelined unsigned restoring divider, several quotient bits per stage
// depends on rbst_pkg
`default_nettype none
module rbst_div #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic [33+FRAC_BITS-1:0]       i_num,
    input  wire logic [31:0]                   i_den,
    output logic      [rbst_pkg::QBITS-1:0]    o_quo,
    output logic                               o_ovf
);
    localparam int NW = 33 + FRAC_BITS;
    localparam int NS = rbst_pkg::DIV_STAGES;
    localparam int ST = rbst_pkg::DIV_STEP;
    localparam int QB = rbst_pkg::QBITS;
    localparam int DW = rbst_pkg::DW;

    logic [NW-1:0] r_rem [0:NS];
    logic [QB-1:0] r_quo [0:NS];
    logic [31:0]   r_den [0:NS];
    logic          r_ovf [0:NS];
    logic [NW-1:0] n_rem [1:NS];
    logic [QB-1:0] n_quo [1:NS];

    always_comb begin
        logic [DW-1:0] rw;
        logic [DW-1:0] dsh;
        logic [QB-1:0] q;
        int idx;
        for (int s = 0; s < NS; s++) begin
            rw = DW'(r_rem[s]);
            q  = r_quo[s];
            for (int b = 0; b < ST; b++) begin
                idx = QB - 1 - s * ST - b;
                dsh = DW'(r_den[s]) << idx;
                if (rw >= dsh) begin
                    rw = rw - dsh;
                    q[idx] = 1'b1;
                end
            end
            n_rem[s+1] = rw[NW-1:0];
            n_quo[s+1] = q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_quo[0] <= '0;
        r_den[0] <= i_den;
        r_ovf[0] <= DW'(i_num) >= (DW'(i_den) << QB);
        for (int s = 1; s <= NS; s++) begin
            r_rem[s] <= n_rem[s];
            r_quo[s] <= n_quo[s];
            r_den[s] <= r_den[s-1];
            r_ovf[s] <= r_ovf[s-1];
        end
    end

    assign o_quo = r_quo[NS];
    assign o_ovf = r_ovf[NS];
endmodule
`default_nettype wire

FILE: rtl/core/ray_box_slab_test_2d_top.sv
// top level of the 2d ray versus axis-aligned box slab test
// depends on rbst_pkg and rbst_div
//
// usage: present one ray/box item on the input ports with start high; it is
// taken at any edge where busy is low, and busy never rises, so one item can
// enter every cycle. each item gives one result on the o_ ports, marked by
// o_valid for exactly one cycle. the accepting edge loads the input register,
// then come the divider pipeline (overflow check plus 8 stages of 4 quotient
// bits each, four dividers in parallel), one saturate/swap stage and one
// interval stage.
// throughput is one item per cycle.
// the receiver cannot stall; results must be taken when o_valid is high.
// i_cfg_we writes i_cfg_data as the parallel epsilon; write it only while
// no item is in flight. reset (i_rst_n low, synchronous) clears all valid
// bits and sets the epsilon to 66; items in flight are dropped.
`default_nettype none
module ray_box_slab_test_2d_top #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [31:0]          i_start_x,
    input  wire logic signed [31:0]          i_start_y,
    input  wire logic signed [31:0]          i_dir_x,
    input  wire logic signed [31:0]          i_dir_y,
    input  wire logic signed [31:0]          i_box_min_x,
    input  wire logic signed [31:0]          i_box_min_y,
    input  wire logic signed [31:0]          i_box_max_x,
    input  wire logic signed [31:0]          i_box_max_y,
    input  wire logic                        i_cfg_we,
    input  wire logic [rbst_pkg::EPS_W-1:0]  i_cfg_data,
    output logic                             o_valid,
    output logic [1:0]                       o_hit_kind,
    output logic                             o_interval_valid,
    output logic signed [31:0]               o_t_enter,
    output logic signed [31:0]               o_t_exit
);
    localparam int NW = 33 + FRAC_BITS;
    localparam int L  = rbst_pkg::DIV_LAT;

    logic [rbst_pkg::EPS_W-1:0] r_eps;
    logic [NW-1:0] r_num_lx, r_num_hx, r_num_ly, r_num_hy;
    logic [31:0]   r_den_x, r_den_y;
    logic          r_v [0:L];
    rbst_pkg::t_side r_side [0:L];
    rbst_pkg::t_side n_side;

    logic signed [32:0] d_lx, d_hx, d_ly, d_hy;
    logic [31:0] m_dx, m_dy;
    logic [32:0] m_lx, m_hx, m_ly, m_hy;
    logic par_x, par_y, out_x, out_y;

    assign busy = 1'b0;

    always_comb begin
        d_lx = 33'(i_box_min_x) - 33'(i_start_x);
        d_hx = 33'(i_box_max_x) - 33'(i_start_x);
        d_ly = 33'(i_box_min_y) - 33'(i_start_y);
        d_hy = 33'(i_box_max_y) - 33'(i_start_y);
        m_lx = d_lx[32] ? 33'(-d_lx) : 33'(d_lx);
        m_hx = d_hx[32] ? 33'(-d_hx) : 33'(d_hx);
        m_ly = d_ly[32] ? 33'(-d_ly) : 33'(d_ly);
        m_hy = d_hy[32] ? 33'(-d_hy) : 33'(d_hy);
        m_dx = i_dir_x[31] ? 32'(-i_dir_x) : 32'(i_dir_x);
        m_dy = i_dir_y[31] ? 32'(-i_dir_y) : 32'(i_dir_y);
        par_x = (m_dx == '0) || (m_dx < {1'b0, r_eps});
        par_y = (m_dy == '0) || (m_dy < {1'b0, r_eps});
        out_x = (i_start_x < i_box_min_x) || (i_box_max_x < i_start_x);
        out_y = (i_start_y < i_box_min_y) || (i_box_max_y < i_start_y);
        n_side.par_x   = par_x;
        n_side.par_y   = par_y;
        n_side.rej     = (par_x && out_x) || (par_y && out_y);
        n_side.dneg_x  = i_dir_x[31];
        n_side.dneg_y  = i_dir_y[31];
        n_side.qneg_lx = d_lx[32] != i_dir_x[31];
        n_side.qneg_hx = d_hx[32] != i_dir_x[31];
        n_side.qneg_ly = d_ly[32] != i_dir_y[31];
        n_side.qneg_hy = d_hy[32] != i_dir_y[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= rbst_pkg::EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= L; s++) r_v[s] <= 1'b0;
        end else begin
            r_v[0] <= start && !busy;
            for (int s = 1; s <= L; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_num_lx <= NW'(m_lx) << FRAC_BITS;
        r_num_hx <= NW'(m_hx) << FRAC_BITS;
        r_num_ly <= NW'(m_ly) << FRAC_BITS;
        r_num_hy <= NW'(m_hy) << FRAC_BITS;
        r_den_x  <= par_x ? 32'd1 : m_dx;
        r_den_y  <= par_y ? 32'd1 : m_dy;
        r_side[0] <= n_side;
        for (int s = 1; s <= L; s++) r_side[s] <= r_side[s-1];
    end

    logic [rbst_pkg::QBITS-1:0] q_lx, q_hx, q_ly, q_hy;
    logic o_lx, o_hx, o_ly, o_hy;

    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_lx (
        .i_clk(i_clk), .i_num(r_num_lx), .i_den(r_den_x), .o_quo(q_lx), .o_ovf(o_lx));
    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_hx (
        .i_clk(i_clk), .i_num(r_num_hx), .i_den(r_den_x), .o_quo(q_hx), .o_ovf(o_hx));
    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_ly (
        .i_clk(i_clk), .i_num(r_num_ly), .i_den(r_den_y), .o_quo(q_ly), .o_ovf(o_ly));
    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_hy (
        .i_clk(i_clk), .i_num(r_num_hy), .i_den(r_den_y), .o_quo(q_hy), .o_ovf(o_hy));

    // saturate, swap for negative direction, unbound parallel axes
    rbst_pkg::t_side sd;
    logic signed [31:0] t_lx, t_hx, t_ly, t_hy;
    logic signed [31:0] n_t0x, n_t1x, n_t0y, n_t1y;
    logic signed [31:0] r_t0x, r_t1x, r_t0y, r_t1y;
    logic r_vs, r_rejs;

    always_comb begin
        sd   = r_side[L];
        t_lx = rbst_pkg::sat_quo(q_lx, o_lx, sd.qneg_lx);
        t_hx = rbst_pkg::sat_quo(q_hx, o_hx, sd.qneg_hx);
        t_ly = rbst_pkg::sat_quo(q_ly, o_ly, sd.qneg_ly);
        t_hy = rbst_pkg::sat_quo(q_hy, o_hy, sd.qneg_hy);
        if (sd.par_x) begin
            n_t0x = rbst_pkg::T_LOWEST;
            n_t1x = rbst_pkg::T_HIGHEST;
        end else if (sd.dneg_x) begin
            n_t0x = t_hx;
            n_t1x = t_lx;
        end else begin
            n_t0x = t_lx;
            n_t1x = t_hx;
        end
        if (sd.par_y) begin
            n_t0y = rbst_pkg::T_LOWEST;
            n_t1y = rbst_pkg::T_HIGHEST;
        end else if (sd.dneg_y) begin
            n_t0y = t_hy;
            n_t1y = t_ly;
        end else begin
            n_t0y = t_ly;
            n_t1y = t_hy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= 1'b0;
        end else begin
            r_vs <= r_v[L];
        end
    end

    always_ff @(posedge i_clk) begin
        r_t0x  <= n_t0x;
        r_t1x  <= n_t1x;
        r_t0y  <= n_t0y;
        r_t1y  <= n_t1y;
        r_rejs <= sd.rej;
    end

    // interval intersection and classification
    logic signed [31:0] tmin, tmax;
    logic ok;
    logic [1:0] n_hit;

    always_comb begin
        tmin = (r_t0x > r_t0y) ? r_t0x : r_t0y;
        tmax = (r_t1x < r_t1y) ? r_t1x : r_t1y;
        ok   = !r_rejs && !(tmax < tmin);
        if (!ok || tmax < 0) n_hit = rbst_pkg::HIT_NONE;
        else if (tmin < 0)   n_hit = rbst_pkg::HIT_INSIDE;
        else                 n_hit = rbst_pkg::HIT_ENTER;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vs;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit_kind       <= n_hit;
        o_interval_valid <= ok;
        o_t_enter        <= ok ? tmin : '0;
        o_t_exit         <= ok ? tmax : '0;
    end
endmodule
`default_nettype wire

FILE: test/tb.sv
// testbench for the 2d ray versus axis-aligned box slab test
// predicts every result from the inputs and the epsilon, checks each strobed result
// depends on rbst_pkg and ray_box_slab_test_2d_top
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int LATENCY = 12;

    typedef struct {
        logic signed [31:0] sx, sy, dx, dy, lx, ly, hx, hy;
    } t_ray_box;

    typedef struct {
        logic [1:0]         kind;
        logic               ivalid;
        logic signed [31:0] t_in;
        logic signed [31:0] t_out;
    } t_slab_hit;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic signed [31:0]          i_start_x = '0, i_start_y = '0, i_dir_x = '0, i_dir_y = '0;
    logic signed [31:0]          i_box_min_x = '0, i_box_min_y = '0;
    logic signed [31:0]          i_box_max_x = '0, i_box_max_y = '0;
    logic                        i_cfg_we = 1'b0;
    logic [rbst_pkg::EPS_W-1:0]  i_cfg_data = '0;
    logic                        o_valid;
    logic [1:0]                  o_hit_kind;
    logic                        o_interval_valid;
    logic signed [31:0]          o_t_enter, o_t_exit;

    logic [rbst_pkg::EPS_W-1:0] epsilon = rbst_pkg::EPS_RESET;
    t_slab_hit        hit_queue[$];
    int               errors = 0;
    bit               quiet = 1'b0;

    ray_box_slab_test_2d_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_start_x(i_start_x), .i_start_y(i_start_y), .i_dir_x(i_dir_x), .i_dir_y(i_dir_y),
        .i_box_min_x(i_box_min_x), .i_box_min_y(i_box_min_y),
        .i_box_max_x(i_box_max_x), .i_box_max_y(i_box_max_y),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_hit_kind(o_hit_kind), .o_interval_valid(o_interval_valid),
        .o_t_enter(o_t_enter), .o_t_exit(o_t_exit)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic signed [63:0] slab_div(logic signed [63:0] diff,
                                                   logic signed [63:0] den);
        logic [63:0] num, q;
        logic        neg;
        num = (diff < 0 ? -diff : diff) << 16;
        q   = num / (den < 0 ? -den : den);
        neg = (diff < 0) != (den < 0);
        if (neg) return (q > 64'h8000_0000) ? -64'sh8000_0000 : -$signed(q);
        return (q > 64'h7fff_ffff) ? 64'sh7fff_ffff : $signed(q);
    endfunction

    function automatic t_slab_hit predict_hit(t_ray_box r);
        logic signed [63:0] tmin, tmax, t0, t1, s, d, lo, hi, tmp;
        logic               ok;
        t_slab_hit          h;
        tmin = -64'sh8000_0000;
        tmax = 64'sh7fff_ffff;
        ok = 1'b1;
        for (int a = 0; a < 2; a++) begin
            if (ok) begin
                s  = a ? r.sy : r.sx;
                d  = a ? r.dy : r.dx;
                lo = a ? r.ly : r.lx;
                hi = a ? r.hy : r.hx;
                if (d == 0 || (d < 0 ? -d : d) < {33'd0, epsilon}) begin
                    if (s < lo || hi < s) ok = 1'b0;
                end else begin
                    t0 = slab_div(lo - s, d);
                    t1 = slab_div(hi - s, d);
                    if (d < 0) begin
                        tmp = t0; t0 = t1; t1 = tmp;
                    end
                    if (t0 > tmin) tmin = t0;
                    if (t1 < tmax) tmax = t1;
                    if (tmax < tmin) ok = 1'b0;
                end
            end
        end
        if (!ok) begin
            h = '{rbst_pkg::HIT_NONE, 1'b0, 32'sd0, 32'sd0};
        end else begin
            h.kind   = (tmax < 0) ? rbst_pkg::HIT_NONE :
                       (tmin < 0) ? rbst_pkg::HIT_INSIDE : rbst_pkg::HIT_ENTER;
            h.ivalid = 1'b1;
            h.t_in   = tmin[31:0];
            h.t_out  = tmax[31:0];
        end
        return h;
    endfunction

    always @(posedge i_clk) begin
        t_slab_hit e;
        if (i_rst_n && start && !busy)
            hit_queue.push_back(predict_hit('{i_start_x, i_start_y, i_dir_x, i_dir_y,
                i_box_min_x, i_box_min_y, i_box_max_x, i_box_max_y}));
        if (o_valid) begin
            if (hit_queue.size() == 0) begin
                $error("result with no item pending");
                errors++;
            end else begin
                e = hit_queue.pop_front();
                if (o_hit_kind !== e.kind) begin
                    $error("hit_kind exp %0d got %0d", e.kind, o_hit_kind); errors++;
                end
                if (o_interval_valid !== e.ivalid) begin
                    $error("interval_valid exp %0d got %0d", e.ivalid, o_interval_valid);
                    errors++;
                end
                if (o_t_enter !== e.t_in) begin
                    $error("t_enter exp %0d got %0d", e.t_in, o_t_enter); errors++;
                end
                if (o_t_exit !== e.t_out) begin
                    $error("t_exit exp %0d got %0d", e.t_out, o_t_exit); errors++;
                end
            end
        end
    end

    task automatic send_item(t_ray_box r);
        if (!quiet) begin
            while ($urandom_range(99) < 13) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
        start <= 1'b1;
        {i_start_x, i_start_y, i_dir_x, i_dir_y} <= {r.sx, r.sy, r.dx, r.dy};
        {i_box_min_x, i_box_min_y, i_box_max_x, i_box_max_y} <= {r.lx, r.ly, r.hx, r.hy};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (hit_queue.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_epsilon(logic [rbst_pkg::EPS_W-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        epsilon = v;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            2: return $signed($urandom_range(255)) - 128;
            default: return $signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_dir();
        case ($urandom_range(6))
            0: return 0;
            1: return $urandom;
            2: return $signed($urandom_range(200)) - 100;
            3: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic t_ray_box rand_ray();
        t_ray_box         r;
        logic signed [31:0] a, b;
        r.sx = rand_coord(); r.sy = rand_coord();
        r.dx = rand_dir();   r.dy = rand_dir();
        a = rand_coord(); b = rand_coord();
        if ($urandom_range(9) != 0 && a > b) begin
            r.lx = b; r.hx = a;
        end else begin
            r.lx = a; r.hx = b;
        end
        a = rand_coord(); b = rand_coord();
        if ($urandom_range(9) != 0 && a > b) begin
            r.ly = b; r.hy = a;
        end else begin
            r.ly = a; r.hy = b;
        end
        return r;
    endfunction

    task automatic test_directed();
        localparam logic signed [31:0] ONE = 32'sh0001_0000;
        localparam logic signed [31:0] MX = 32'sh7fff_ffff, MN = 32'sh8000_0000;
        // from the left, passes above the box (empty interval)
        send_item('{-ONE*4, 0, ONE, ONE/2, -ONE, -ONE, ONE, ONE});
        // starts inside
        send_item('{0, 0, ONE, -ONE, -ONE, -ONE, ONE, ONE});
        // box behind the ray
        send_item('{ONE*4, 0, ONE, 0, -ONE, -ONE, ONE, ONE});
        // parallel axis outside slab
        send_item('{0, ONE*3, ONE, 0, -ONE, -ONE, ONE, ONE});
        // both axes parallel, inside
        send_item('{0, 0, 0, 0, -ONE, -ONE, ONE, ONE});
        // below epsilon
        send_item('{0, 0, 32'sd65, -32'sd65, -ONE, -ONE, ONE, ONE});
        // reversed box
        send_item('{0, 0, 0, 0, ONE, ONE, -ONE, -ONE});
        send_item('{-ONE*4, 0, ONE, ONE, ONE, ONE, -ONE, -ONE});
        // saturating quotients
        send_item('{MN, MN, 32'sd66, 32'sd66, MN, MN, MX, MX});
        send_item('{MX, MX, MN, MN, MN, MN, MX, MX});
        send_item('{MX, MN, MX, MX, MN, MN, MX, MX});
        // empty interval
        send_item('{-ONE*4, -ONE*4, ONE, -ONE, -ONE, -ONE, ONE, ONE});
        send_item('{32'sh5555_aaaa, -32'sh5555_aaab, 32'sh2aaa_5555, -32'sh2aaa_5556,
                    32'sh1234_5678, -32'sh1234_5679, 32'sh7654_3210, -32'sh0765_4321});
    endtask

    task automatic test_epsilon_zero();
        write_epsilon('0);
        send_item('{0, 0, 0, 32'sd1, -32'sd5, -32'sd5, 32'sd5, 32'sd5});
        send_item('{0, 0, -32'sd1, 0, -32'sd5, -32'sd5, 32'sd5, 32'sd5});
        repeat (100) send_item(rand_ray());
    endtask

    task automatic test_epsilon_max();
        write_epsilon({rbst_pkg::EPS_W{1'b1}});
        send_item('{0, 0, 32'sh7fff_fffe, 32'sh8000_0000, -32'sd5, -32'sd5, 32'sd5, 32'sd5});
        repeat (100) send_item(rand_ray());
    endtask

    task automatic test_random();
        write_epsilon(rbst_pkg::EPS_RESET);
        repeat (300) send_item(rand_ray());
        quiet = 1'b1;
        repeat (150) send_item(rand_ray());
        quiet = 1'b0;
        write_epsilon(31'h0001_0000);
        repeat (180) send_item(rand_ray());
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_epsilon_zero();
        test_epsilon_max();
        test_random();
        drain();
        if (errors == 0 && hit_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/rbst_pkg.sv
rtl/core/rbst_div.sv
rtl/core/ray_box_slab_test_2d_top.sv
test/tb.sv
